[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gpt: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define GPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gpt: next-cycle property violated");

`endif

[rtl/core/gpt_pkg.sv]
// Constants and types for the Gaussian polar transform core.
// No dependencies; used by gaussian_polar_transform.
`timescale 1ns / 1ps

package gpt_pkg;

    // Fixed-point formats (input widths are fixed at 16 bits)
    localparam int UNIFORM_FRAC_BITS = 15;
    localparam int OUT_FRAC_BITS     = 16;
    localparam int TWO_F             = 2 * UNIFORM_FRAC_BITS;

    // ln(2) in Q0.26
    localparam logic [25:0] LN2_Q26 = 26'd46516320;

    // Pipeline geometry
    localparam int LOG_STEPS = 30;   // log2 fraction bits, one per stage
    localparam int DIV_STEPS = 32;   // quotient bits, one per stage
    localparam int SQ_STEPS  = 32;   // root bits, one per stage
    localparam int SIG_STEPS = 24;   // sigma root bits, one per cycle

    // Shift of |x|*G into Q.32: e/2 + 4 - F
    localparam int SH_BIAS = UNIFORM_FRAC_BITS - 4;
    // Product shift to output format
    localparam int D_SHIFT = 48 - OUT_FRAC_BITS;

    // Register reset values
    localparam logic signed [31:0] MEAN_RESET = 32'sd0;
    localparam logic [23:0]        SIG_RESET  = 24'd65536; // sqrt(65536 << 16)

    typedef enum logic [7:0] {
        CFG_MEAN_VALUE = 8'd0,
        CFG_VARIANCE   = 8'd1
    } t_cfg_index;

    // Sideband carried along the datapath
    typedef struct packed {
        logic signed [15:0] u;
        logic signed [15:0] v;
        logic [4:0]         e;   // exponent 2F-p; holds e/2 after the divider
    } t_side;

endpackage

[rtl/core/gaussian_polar_transform.sv]
// Gaussian polar transform: Marsaglia polar method in fixed point, fully pipelined.
// Depends on gpt_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// Takes a pair of signed Q1.15 uniforms per transaction (start high while busy is
// low) and emits two Q15.16 Gaussian samples, u-side first, then v-side with
// o_last set. Each sample is on o_sample for exactly one cycle with o_strobe high;
// the receiver cannot stall, so nothing ever backs up. A pair with s = u^2 + v^2
// equal to zero or not below one is dropped and produces no strobe. New pairs are
// accepted while earlier ones are still in flight, but busy rises for the cycle
// after each accepted transaction, since the single result port carries one
// sample per cycle. The first sample reaches the port after the capture, square,
// reject, log2, ln, divider, root, scaling and output registers; the second
// follows in the next cycle. Writing the variance register starts a bit-serial
// square-root sequence for sigma. The config port is always ready; unknown
// indexes are ignored.
module gaussian_polar_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_u_value,
    input  logic signed [15:0] i_v_value,
    // result channel
    output logic               o_strobe,
    output logic signed [31:0] o_sample,
    output logic               o_last,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int LS = gpt_pkg::LOG_STEPS;
    localparam int DS = gpt_pkg::DIV_STEPS;
    localparam int QS = gpt_pkg::SQ_STEPS;

    // ------------------------------------------------------------------
    // Configuration: mean register and iterative sigma = isqrt(var << 16)
    // ------------------------------------------------------------------
    logic signed [31:0] r_mean;
    logic [23:0]        r_sig;
    logic               r_sg_busy;
    logic [4:0]         r_sg_cnt;
    logic [47:0]        r_sg_x;
    logic [25:0]        r_sg_rem;
    logic [23:0]        r_sg_root;
    logic [27:0]        sg_r2;
    logic [27:0]        sg_t;
    logic               sg_ge;
    logic               cfg_wr;
    logic               sg_load;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign sg_load     = cfg_wr && (i_cfg_index == gpt_pkg::CFG_VARIANCE);

    // one root digit per cycle
    assign sg_r2 = {r_sg_rem, r_sg_x[47:46]};
    assign sg_t  = {2'b00, r_sg_root, 2'b01};
    assign sg_ge = (sg_r2 >= sg_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean    <= gpt_pkg::MEAN_RESET;
            r_sig     <= gpt_pkg::SIG_RESET;
            r_sg_busy <= 1'b0;
            r_sg_cnt  <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    gpt_pkg::CFG_MEAN_VALUE: begin
                        r_mean <= i_cfg_data;
                    end
                    gpt_pkg::CFG_VARIANCE: begin
                        r_sg_busy <= 1'b1;
                        r_sg_cnt  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            // root steps run on through writes to other registers
            if (r_sg_busy && !sg_load) begin
                r_sg_cnt <= r_sg_cnt + 5'd1;
                if (r_sg_cnt == 5'(gpt_pkg::SIG_STEPS - 1)) begin
                    r_sg_busy <= 1'b0;
                    r_sig     <= {r_sg_root[22:0], sg_ge};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sg_load) begin
            r_sg_x    <= {i_cfg_data, 16'd0};
            r_sg_rem  <= '0;
            r_sg_root <= '0;
        end else if (r_sg_busy) begin
            r_sg_x    <= {r_sg_x[45:0], 2'b00};
            r_sg_rem  <= sg_ge ? 26'(sg_r2 - sg_t) : sg_r2[25:0];
            r_sg_root <= {r_sg_root[22:0], sg_ge};
        end
    end

    // ------------------------------------------------------------------
    // Intake: a new transaction is taken only while busy is low
    // ------------------------------------------------------------------
    logic r_busy;
    logic accept;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    // s0: input capture
    logic               r_s0_valid;
    logic signed [15:0] r_s0_u, r_s0_v;
    // s1: squares
    logic               r_s1_valid;
    logic signed [15:0] r_s1_u, r_s1_v;
    logic [30:0]        r_s1_uu, r_s1_vv;
    // s2: sum and reject
    logic               r_s2_valid;
    logic signed [15:0] r_s2_u, r_s2_v;
    logic [31:0]        r_s2_s;
    logic [31:0]        s2_sum;

    assign s2_sum = 32'(r_s1_uu) + 32'(r_s1_vv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s0_valid <= accept;
            r_s1_valid <= r_s0_valid;
            // s == 0 and s >= 1.0 are rejected here and leave no trace
            r_s2_valid <= r_s1_valid && (s2_sum != 32'd0)
                          && (s2_sum < (32'd1 << gpt_pkg::TWO_F));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_u <= i_u_value;
            r_s0_v <= i_v_value;
        end
        r_s1_u  <= r_s0_u;
        r_s1_v  <= r_s0_v;
        r_s1_uu <= 31'(32'(r_s0_u * r_s0_u));
        r_s1_vv <= 31'(32'(r_s0_v * r_s0_v));
        r_s2_u  <= r_s1_u;
        r_s2_v  <= r_s1_v;
        r_s2_s  <= s2_sum;
    end

    // ------------------------------------------------------------------
    // log2 by repeated squaring: one fraction bit per stage
    // ------------------------------------------------------------------
    logic                r_lg_valid [0:LS];
    logic [30:0]         r_lg_m     [0:LS];
    logic [30:0]         r_lg_m0    [0:LS];
    logic [LS-1:0]       r_lg_f     [0:LS];
    gpt_pkg::t_side      r_lg_side  [0:LS];

    logic [4:0]  nrm_p;
    logic [30:0] nrm_m;

    // leading one of s; p stays below 30 for any pair that survives the reject
    always_comb begin
        nrm_p = '0;
        for (int i = 0; i < 30; i++) begin
            if (r_s2_s[i]) nrm_p = 5'(i);
        end
        nrm_m = 31'({1'b0, r_s2_s[29:0]} << (5'd30 - nrm_p));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_valid[0] <= 1'b0;
        end else begin
            r_lg_valid[0] <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lg_m[0]      <= nrm_m;
        r_lg_m0[0]     <= nrm_m;
        r_lg_f[0]      <= '0;
        r_lg_side[0].u <= r_s2_u;
        r_lg_side[0].v <= r_s2_v;
        r_lg_side[0].e <= 5'(gpt_pkg::TWO_F) - nrm_p;
    end

    for (genvar k = 0; k < LS; k++) begin : g_log
        logic [61:0] sq;
        logic [31:0] sq_hi;

        assign sq    = 62'(r_lg_m[k]) * 62'(r_lg_m[k]);
        assign sq_hi = sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_valid[k+1] <= 1'b0;
            end else begin
                r_lg_valid[k+1] <= r_lg_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_lg_m0[k+1]   <= r_lg_m0[k];
            r_lg_side[k+1] <= r_lg_side[k];
            if (sq_hi[31]) begin
                r_lg_m[k+1] <= sq_hi[31:1];
                r_lg_f[k+1] <= r_lg_f[k] | (LS'(1) << (LS - 1 - k));
            end else begin
                r_lg_m[k+1] <= sq_hi[30:0];
                r_lg_f[k+1] <= r_lg_f[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // -log2(s) in Q.30, then -2 ln(s) = that * ln2 * 2
    // ------------------------------------------------------------------
    logic           r_ng_valid;
    logic [34:0]    r_ng;
    logic [30:0]    r_ng_m;
    gpt_pkg::t_side r_ng_side;
    logic           r_w_valid;
    logic [35:0]    r_w;
    logic [30:0]    r_w_m;
    gpt_pkg::t_side r_w_side;
    logic [60:0]    w_prod;

    assign w_prod = 61'(r_ng) * 61'(gpt_pkg::LN2_Q26);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ng_valid <= 1'b0;
            r_w_valid  <= 1'b0;
        end else begin
            r_ng_valid <= r_lg_valid[LS];
            r_w_valid  <= r_ng_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ng      <= {r_lg_side[LS].e, 30'd0} - 35'(r_lg_f[LS]);
        r_ng_m    <= r_lg_m0[LS];
        r_ng_side <= r_lg_side[LS];
        r_w       <= w_prod[60:25];
        r_w_m     <= r_ng_m;
        r_w_side  <= r_ng_side;
    end

    // ------------------------------------------------------------------
    // q = (w << 26) / m: restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic           r_dv_valid [0:DS];
    logic [30:0]    r_dv_rem   [0:DS];
    logic [31:0]    r_dv_lo    [0:DS];
    logic [31:0]    r_dv_q     [0:DS];
    logic [30:0]    r_dv_m     [0:DS];
    gpt_pkg::t_side r_dv_side  [0:DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else begin
            r_dv_valid[0] <= r_w_valid;
        end
    end

    // upper dividend bits are below m, so the quotient fits 32 bits
    always_ff @(posedge i_clk) begin
        r_dv_rem[0]  <= {1'b0, r_w[35:6]};
        r_dv_lo[0]   <= {r_w[5:0], 26'd0};
        r_dv_q[0]    <= '0;
        r_dv_m[0]    <= r_w_m;
        r_dv_side[0] <= r_w_side;
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [31:0] trial;
        logic        ge;

        assign trial = {r_dv_rem[k], r_dv_lo[k][31]};
        assign ge    = (trial >= {1'b0, r_dv_m[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_rem[k+1]  <= ge ? 31'(trial - {1'b0, r_dv_m[k]}) : trial[30:0];
            r_dv_lo[k+1]   <= {r_dv_lo[k][30:0], 1'b0};
            r_dv_q[k+1]    <= {r_dv_q[k][30:0], ge};
            r_dv_m[k+1]    <= r_dv_m[k];
            r_dv_side[k+1] <= r_dv_side[k];
        end
    end

    // ------------------------------------------------------------------
    // G = isqrt(q << 30), odd exponent folded into q on entry
    // ------------------------------------------------------------------
    logic           r_sq_valid [0:QS];
    logic [33:0]    r_sq_rem   [0:QS];
    logic [31:0]    r_sq_root  [0:QS];
    logic [63:0]    r_sq_x     [0:QS];
    gpt_pkg::t_side r_sq_side  [0:QS];
    logic [32:0]    sq_q;

    assign sq_q = r_dv_side[DS].e[0] ? {r_dv_q[DS], 1'b0} : {1'b0, r_dv_q[DS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else begin
            r_sq_valid[0] <= r_dv_valid[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]    <= '0;
        r_sq_root[0]   <= '0;
        r_sq_x[0]      <= {1'b0, sq_q, 30'd0};
        r_sq_side[0].u <= r_dv_side[DS].u;
        r_sq_side[0].v <= r_dv_side[DS].v;
        r_sq_side[0].e <= {1'b0, r_dv_side[DS].e[4:1]};   // e/2 from here on
    end

    for (genvar k = 0; k < QS; k++) begin : g_sqrt
        logic [35:0] r2;
        logic [35:0] t;
        logic        ge;

        assign r2 = {r_sq_rem[k], r_sq_x[k][63:62]};
        assign t  = {2'b00, r_sq_root[k], 2'b01};
        assign ge = (r2 >= t);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[k+1]  <= ge ? 34'(r2 - t) : r2[33:0];
            r_sq_root[k+1] <= {r_sq_root[k][30:0], ge};
            r_sq_x[k+1]    <= {r_sq_x[k][61:0], 2'b00};
            r_sq_side[k+1] <= r_sq_side[k];
        end
    end

    // ------------------------------------------------------------------
    // Scaling: |x|*G, shift to Q.32, times sigma, then mean +/- d
    // ------------------------------------------------------------------
    logic           r_f1_valid;
    logic [47:0]    r_f1_au, r_f1_av;
    gpt_pkg::t_side r_f1_side;
    logic           r_f2_valid;
    logic [35:0]    r_f2_zu, r_f2_zv;
    logic           r_f2_nu, r_f2_nv;
    logic           r_f3_valid;
    logic [59:0]    r_f3_pu, r_f3_pv;
    logic           r_f3_nu, r_f3_nv;

    logic [15:0] mag_u, mag_v;
    logic [51:0] zw_u, zw_v;
    logic [3:0]  sh_e;

    assign mag_u = r_sq_side[QS].u[15] ? 16'(-r_sq_side[QS].u) : 16'(r_sq_side[QS].u);
    assign mag_v = r_sq_side[QS].v[15] ? 16'(-r_sq_side[QS].v) : 16'(r_sq_side[QS].v);
    assign sh_e  = r_f1_side.e[3:0];

    // |x|*g stays below 7 in Q.32, so 36 bits hold z
    always_comb begin
        if (sh_e >= 4'(gpt_pkg::SH_BIAS)) begin
            zw_u = 52'(r_f1_au) << (sh_e - 4'(gpt_pkg::SH_BIAS));
            zw_v = 52'(r_f1_av) << (sh_e - 4'(gpt_pkg::SH_BIAS));
        end else begin
            zw_u = 52'(r_f1_au) >> (4'(gpt_pkg::SH_BIAS) - sh_e);
            zw_v = 52'(r_f1_av) >> (4'(gpt_pkg::SH_BIAS) - sh_e);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else begin
            r_f1_valid <= r_sq_valid[QS];
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_au   <= 48'(mag_u) * 48'(r_sq_root[QS]);
        r_f1_av   <= 48'(mag_v) * 48'(r_sq_root[QS]);
        r_f1_side <= r_sq_side[QS];
        r_f2_zu   <= zw_u[35:0];
        r_f2_zv   <= zw_v[35:0];
        r_f2_nu   <= r_f1_side.u[15];
        r_f2_nv   <= r_f1_side.v[15];
        r_f3_pu   <= 60'(r_f2_zu) * 60'(r_sig);
        r_f3_pv   <= 60'(r_f2_zv) * 60'(r_sig);
        r_f3_nu   <= r_f2_nu;
        r_f3_nv   <= r_f2_nv;
    end

    // mean +/- d with saturation, both lanes
    logic [27:0]        d_u, d_v;
    logic signed [33:0] sum_u, sum_v;
    logic signed [31:0] sat_u, sat_v;

    assign d_u = 28'(r_f3_pu >> gpt_pkg::D_SHIFT);
    assign d_v = 28'(r_f3_pv >> gpt_pkg::D_SHIFT);

    always_comb begin
        sum_u = r_f3_nu ? (34'(r_mean) - $signed({6'd0, d_u}))
                        : (34'(r_mean) + $signed({6'd0, d_u}));
        sum_v = r_f3_nv ? (34'(r_mean) - $signed({6'd0, d_v}))
                        : (34'(r_mean) + $signed({6'd0, d_v}));
        if (sum_u > 34'sd2147483647)       sat_u = 32'sh7fffffff;
        else if (sum_u < -34'sd2147483648) sat_u = 32'sh80000000;
        else                               sat_u = 32'(sum_u);
        if (sum_v > 34'sd2147483647)       sat_v = 32'sh7fffffff;
        else if (sum_v < -34'sd2147483648) sat_v = 32'sh80000000;
        else                               sat_v = 32'(sum_v);
    end

    // ------------------------------------------------------------------
    // Result port: u-side sample now, v-side sample parked for next cycle.
    // Intake never accepts pairs back to back, so the park slot is always free.
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic               r_out_last;
    logic signed [31:0] r_out_sample;
    logic               r_pend_valid;
    logic signed [31:0] r_pend_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_f3_valid) begin
                r_out_valid  <= 1'b1;
                r_out_last   <= 1'b0;
                r_pend_valid <= 1'b1;
            end else if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_out_last   <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= 1'b0;
                r_out_last   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f3_valid) begin
            r_out_sample  <= sat_u;
            r_pend_sample <= sat_v;
        end else if (r_pend_valid) begin
            r_out_sample  <= r_pend_sample;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_last   = r_out_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `GPT_ASSERT_NXT(a_first_then_last, i_clk, i_rst_n, o_strobe && !o_last, o_strobe && o_last)
    `GPT_ASSERT_IMP(a_last_has_first, i_clk, i_rst_n, o_strobe && o_last, $past(o_strobe) && !$past(o_last))
    `GPT_ASSERT_IMP(a_park_free, i_clk, i_rst_n, r_f3_valid, !r_pend_valid)

endmodule
